// ----- design/rdnc_pkg.sv -----
// Shared types and constants of the nearest centroid classifier core.
`default_nettype none
package rdnc_pkg;

   localparam int SUM_W      = 38;
   localparam int RMS_W      = 19;
   localparam int REM_W      = RMS_W + 3;
   localparam int SQRT_CNT_W = $clog2(RMS_W + 1);
   localparam int CLASS_W    = 2;
   localparam int ID_W       = 8;
   localparam int TICK_W     = 20;
   localparam int ISSUE_W    = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 20;

   localparam logic [ISSUE_W-1:0] ISSUE_LIMIT = 2'd3;
   localparam logic [TICK_W-1:0]  TICK_RESET  = 20'd1000;

   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_TICK   = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_CENTROID_ZERO  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTROID_ONE   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTROID_TWO   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_INTERVAL_TICKS = 2'd3;

   localparam logic [CLASS_W-1:0] CLASS_ZERO = 2'd0;
   localparam logic [CLASS_W-1:0] CLASS_ONE  = 2'd1;
   localparam logic [CLASS_W-1:0] CLASS_TWO  = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_ROOT,
      ST_PICK
   } rdnc_state_type;

endpackage
`default_nettype wire

// ----- design/rdnc_sqmac.sv -----
// Bit-serial delta squarer with saturating sum accumulator.
`default_nettype none
module rdnc_sqmac #(
   parameter int SAMPLE_BITS = 16
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic                       clear,
   input  wire logic [SAMPLE_BITS-1:0]     delta,
   output logic                            busy,
   output logic [rdnc_pkg::SUM_W-1:0]      sum
);
   import rdnc_pkg::*;

   localparam int PROD_W = 2 * SAMPLE_BITS;
   localparam int ACC_W  = ((PROD_W > SUM_W) ? PROD_W : SUM_W) + 1;

   logic [PROD_W-1:0]      mcand_ff, mcand_in;
   logic [SAMPLE_BITS-1:0] mplier_ff, mplier_in;
   logic [PROD_W-1:0]      prod_ff, prod_in;
   logic [SUM_W-1:0]       sum_ff, sum_in;
   logic                   step_ff, step_in;
   logic                   fold_ff, fold_in;
   logic [PROD_W-1:0]      prod_add;
   logic [ACC_W-1:0]       acc;
   logic [ACC_W-1:0]       sum_max_ext;

   always_comb begin
      prod_add    = mplier_ff[0] ? mcand_ff : '0;
      sum_max_ext = {{(ACC_W-SUM_W){1'b0}}, {SUM_W{1'b1}}};
      acc         = ACC_W'(sum_ff) + ACC_W'(prod_ff);
      mcand_in    = mcand_ff;
      mplier_in   = mplier_ff;
      prod_in     = prod_ff;
      step_in     = step_ff;
      fold_in     = 1'b0;
      sum_in      = sum_ff;
      if (start) begin
         mcand_in  = PROD_W'(delta);
         mplier_in = delta;
         prod_in   = '0;
         step_in   = 1'b1;
      end else if (step_ff) begin
         prod_in   = prod_ff + prod_add;
         mcand_in  = mcand_ff << 1;
         mplier_in = mplier_ff >> 1;
         if (mplier_ff[SAMPLE_BITS-1:1] == '0) begin
            step_in = 1'b0;
            fold_in = 1'b1;
         end
      end
      if (fold_ff) begin
         sum_in = (acc > sum_max_ext) ? {SUM_W{1'b1}} : acc[SUM_W-1:0];
      end
      if (clear) begin
         sum_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      prod_ff   <= prod_in;
      if (reset) begin
         step_ff <= 1'b0;
         fold_ff <= 1'b0;
         sum_ff  <= '0;
      end else begin
         step_ff <= step_in;
         fold_ff <= fold_in;
         sum_ff  <= sum_in;
      end
   end

   assign busy = step_ff | fold_ff;
   assign sum  = sum_ff;

endmodule
`default_nettype wire

// ----- design/rdnc_sqrt.sv -----
// Digit-serial floor square root, two radicand bits per cycle.
`default_nettype none
module rdnc_sqrt (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [rdnc_pkg::SUM_W-1:0] radicand,
   output logic                            busy,
   output logic [rdnc_pkg::RMS_W-1:0]      root
);
   import rdnc_pkg::*;

   logic [SUM_W-1:0]      rad_ff, rad_in;
   logic [REM_W-1:0]      rem_ff, rem_in;
   logic [RMS_W-1:0]      root_ff, root_in;
   logic [SQRT_CNT_W-1:0] cnt_ff, cnt_in;
   logic                  run_ff, run_in;
   logic [REM_W-1:0]      rem_sh;
   logic [REM_W-1:0]      trial;
   logic                  ge;

   always_comb begin
      rem_sh  = {rem_ff[REM_W-3:0], rad_ff[SUM_W-1 -: 2]};
      trial   = {1'b0, root_ff, 2'b01};
      ge      = rem_sh >= trial;
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      if (start) begin
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = SQRT_CNT_W'(RMS_W);
         run_in  = 1'b1;
      end else if (run_ff) begin
         rad_in  = rad_ff << 2;
         rem_in  = ge ? (rem_sh - trial) : rem_sh;
         root_in = {root_ff[RMS_W-2:0], ge};
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == SQRT_CNT_W'(1)) begin
            run_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         run_ff <= 1'b0;
      end else begin
         run_ff <= run_in;
      end
   end

   assign busy = run_ff;
   assign root = root_ff;

endmodule
`default_nettype wire

// ----- design/rms_delta_nearest_centroid_classifier_core.sv -----
// Top level: sample intake, issue window, centroid pick and result register.
// Tick and first/overlong samples need no arithmetic; a delta sample runs the serial squarer,
// one shift-add step per significant bit of |delta| (at least one), then a saturating fold.
// A last sample then adds the serial square root, a handover and the centroid pick.
// One item is in work at a time; a held result stalls intake only once the next result is
// ready. Reset clears control, sum and window state, centroids to 0, interval_ticks to 1000.
`default_nettype none
module rms_delta_nearest_centroid_classifier_core #(
   parameter int SAMPLES_PER_MESSAGE = 60,
   parameter int SAMPLE_BITS         = 16
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic                            req_operation,
   input  wire logic [SAMPLE_BITS-1:0]          req_sample_value,
   input  wire logic [rdnc_pkg::ID_W-1:0]       req_source_id,
   input  wire logic                            req_last_sample,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic                                 rsp_class_valid,
   output logic [rdnc_pkg::CLASS_W-1:0]         rsp_class_index,
   output logic [rdnc_pkg::ID_W-1:0]            rsp_destination_id,
   output logic [rdnc_pkg::RMS_W-1:0]           rsp_rms_value,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [rdnc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [rdnc_pkg::CSR_DATA_W-1:0] csr_data
);
   import rdnc_pkg::*;

   localparam int IDX_W = $clog2(SAMPLES_PER_MESSAGE + 1);

   rdnc_state_type state_ff, state_in;

   logic [RMS_W-1:0]       cent0_ff, cent1_ff, cent2_ff;
   logic [TICK_W-1:0]      interval_ff;
   logic [SAMPLE_BITS-1:0] prev_ff, prev_in;
   logic [IDX_W-1:0]       index_ff, index_in;
   logic [ISSUE_W-1:0]     issued_ff, issued_in;
   logic                   running_ff, running_in;
   logic [TICK_W-1:0]      remaining_ff, remaining_in;
   logic                   last_ff;
   logic [ID_W-1:0]        src_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_class_valid_ff;
   logic [CLASS_W-1:0]     rsp_class_index_ff;
   logic [ID_W-1:0]        rsp_dest_ff;
   logic [RMS_W-1:0]       rsp_rms_ff;

   logic                   req_fire, is_tick, take, needs_square;
   logic                   sq_start, rt_start, pick_load;
   logic                   sq_busy, rt_busy;
   logic [SUM_W-1:0]       sq_sum;
   logic [RMS_W-1:0]       rt_root;
   logic [SAMPLE_BITS-1:0] delta;
   logic [RMS_W-1:0]       diff0, diff1, diff2, best_diff;
   logic [CLASS_W-1:0]     best;
   logic                   issue_ok;

   assign req_fire     = req_valid && req_ready;
   assign is_tick      = req_operation == OP_TICK;
   assign take         = index_ff < IDX_W'(SAMPLES_PER_MESSAGE);
   assign needs_square = take && (index_ff != '0);
   assign delta        = (req_sample_value >= prev_ff) ? (req_sample_value - prev_ff)
                                                       : (prev_ff - req_sample_value);
   assign csr_ready    = 1'b1;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && !is_tick) begin
               if (needs_square) begin
                  state_in = ST_SQUARE;
               end else if (req_last_sample) begin
                  state_in = ST_ROOT;
               end
            end
         end
         ST_SQUARE: begin
            if (!sq_busy) begin
               state_in = last_ff ? ST_ROOT : ST_IDLE;
            end
         end
         ST_ROOT: begin
            if (!rt_busy) begin
               state_in = ST_PICK;
            end
         end
         ST_PICK: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      sq_start  = 1'b0;
      rt_start  = 1'b0;
      pick_load = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            sq_start  = req_fire && !is_tick && needs_square;
            rt_start  = req_fire && !is_tick && !needs_square && req_last_sample;
         end
         ST_SQUARE: begin
            rt_start = !sq_busy && last_ff;
         end
         ST_PICK: begin
            pick_load = !rsp_valid_ff || rsp_ready;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   rdnc_sqmac #(
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_sqmac (
      .clock (clock),
      .reset (reset),
      .start (sq_start),
      .clear (pick_load),
      .delta (delta),
      .busy  (sq_busy),
      .sum   (sq_sum)
   );

   rdnc_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (rt_start),
      .radicand (sq_sum),
      .busy     (rt_busy),
      .root     (rt_root)
   );

   always_comb begin
      diff0 = (rt_root >= cent0_ff) ? (rt_root - cent0_ff) : (cent0_ff - rt_root);
      diff1 = (rt_root >= cent1_ff) ? (rt_root - cent1_ff) : (cent1_ff - rt_root);
      diff2 = (rt_root >= cent2_ff) ? (rt_root - cent2_ff) : (cent2_ff - rt_root);
      best      = CLASS_ZERO;
      best_diff = diff0;
      if (diff1 < best_diff) begin
         best      = CLASS_ONE;
         best_diff = diff1;
      end
      if (diff2 < best_diff) begin
         best = CLASS_TWO;
      end
   end

   assign issue_ok = issued_ff < ISSUE_LIMIT;

   always_comb begin
      prev_in      = prev_ff;
      index_in     = index_ff;
      issued_in    = issued_ff;
      running_in   = running_ff;
      remaining_in = remaining_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (req_fire) begin
         if (is_tick) begin
            if (running_ff) begin
               if (remaining_ff <= TICK_W'(1)) begin
                  remaining_in = '0;
                  running_in   = 1'b0;
                  issued_in    = '0;
               end else begin
                  remaining_in = remaining_ff - 1'b1;
               end
            end
         end else if (take) begin
            prev_in  = req_sample_value;
            index_in = index_ff + 1'b1;
         end
      end
      if (pick_load) begin
         rsp_valid_in = 1'b1;
         prev_in      = '0;
         index_in     = '0;
         if (issue_ok) begin
            issued_in = issued_ff + 1'b1;
            if (!running_ff) begin
               running_in   = 1'b1;
               remaining_in = interval_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && !is_tick) begin
         last_ff <= req_last_sample;
         src_ff  <= req_source_id;
      end
      if (pick_load) begin
         rsp_class_valid_ff <= issue_ok;
         rsp_class_index_ff <= issue_ok ? best : CLASS_ZERO;
         rsp_dest_ff        <= src_ff;
         rsp_rms_ff         <= rt_root;
      end
      if (reset) begin
         state_ff     <= ST_IDLE;
         cent0_ff     <= '0;
         cent1_ff     <= '0;
         cent2_ff     <= '0;
         interval_ff  <= TICK_RESET;
         prev_ff      <= '0;
         index_ff     <= '0;
         issued_ff    <= '0;
         running_ff   <= 1'b0;
         remaining_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         prev_ff      <= prev_in;
         index_ff     <= index_in;
         issued_ff    <= issued_in;
         running_ff   <= running_in;
         remaining_ff <= remaining_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_CENTROID_ZERO:  cent0_ff    <= csr_data[RMS_W-1:0];
               CSR_CENTROID_ONE:   cent1_ff    <= csr_data[RMS_W-1:0];
               CSR_CENTROID_TWO:   cent2_ff    <= csr_data[RMS_W-1:0];
               CSR_INTERVAL_TICKS: interval_ff <= csr_data[TICK_W-1:0];
               default:            interval_ff <= interval_ff;
            endcase
         end
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_class_valid    = rsp_class_valid_ff;
   assign rsp_class_index    = rsp_class_index_ff;
   assign rsp_destination_id = rsp_dest_ff;
   assign rsp_rms_value      = rsp_rms_ff;

   a_ready_units_idle : assert property (@(posedge clock) disable iff (reset)
      req_ready |-> (!sq_busy && !rt_busy))
      else $error("item accepted while an arithmetic unit is busy");

   a_issue_limit : assert property (@(posedge clock) disable iff (reset)
      issued_ff <= ISSUE_LIMIT)
      else $error("issue count beyond limit");

   a_idle_window_clear : assert property (@(posedge clock) disable iff (reset)
      !running_ff |-> (issued_ff == '0))
      else $error("issues counted with window timer idle");

   a_gated_index : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_class_valid_ff) |-> (rsp_class_index_ff == CLASS_ZERO))
      else $error("gated item carries a class index");

   a_pick_from_root : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PICK) |-> ($past(state_ff) == ST_ROOT || $past(state_ff) == ST_PICK))
      else $error("centroid pick without square root");

endmodule
`default_nettype wire
